// ===== sv/nctv_pkg.sv =====
// ----------------------------------------------------------------------------
// Note-to-CV glide lane package
// Shared constants, codes, command/status types and a helper function.
// ----------------------------------------------------------------------------
package nctv_pkg;

   localparam int MinPitch = 24;
   localparam int DacMaxMv = 5000;

   localparam int CvW     = 13;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 16;
   localparam int QuotW   = 21;

   // floor(y / 127) = (y * LevelRecip) >> 19 for y < 4096
   localparam logic [12:0] LevelRecip = 13'd4129;

   localparam logic [4:0] DivStepsWide = 5'd21;
   localparam logic [4:0] DivStepsRamp = 5'd13;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_SET   = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;
   localparam logic [1:0] FUNC_TICK  = 2'd3;

   localparam logic [CsrIdxW-1:0] REG_LANE_SECOND = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_MODE_BITS   = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_DETUNE      = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_BEND_RANGE  = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_OFFSET      = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_MV_PER_SEMI = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_GLIDE_MS    = 3'd6;

   localparam int MODE_GLIDE_OFF = 0;
   localparam int MODE_BEND_OFF  = 1;
   localparam int MODE_LEGATO    = 2;
   localparam int MODE_CHROMATIC = 3;
   localparam int MODE_PROP      = 4;

   typedef struct packed {
      logic load;
      logic note_rel;
      logic note_mul;
      logic note_clamp;
      logic set_cv;
      logic gap_start;
      logic ramp_fixed;
      logic ramp_prop;
      logic stop;
      logic tick;
      logic eval_end;
      logic ramp_mul;
      logic ramp_div;
      logic quant_start;
      logic cv_from_div;
      logic quant_mul;
      logic quant_clamp;
      logic result;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       ramp_on;
      logic       ramp_end;
      logic       no_glide;
      logic       prop;
      logic       chrom;
      logic       div_busy;
      logic       rsp_free;
   } sts_type;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_NOTE   = 14'b00000000000010,
      S_MUL    = 14'b00000000000100,
      S_CLAMP  = 14'b00000000001000,
      S_ROUTE  = 14'b00000000010000,
      S_GAPW   = 14'b00000000100000,
      S_PLEN   = 14'b00000001000000,
      S_EVAL   = 14'b00000010000000,
      S_RDIV   = 14'b00000100000000,
      S_RWAIT  = 14'b00001000000000,
      S_QWAIT  = 14'b00010000000000,
      S_QMUL   = 14'b00100000000000,
      S_QCLAMP = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   function automatic logic [CvW-1:0] clamp_mv(input logic signed [31:0] mv);
      logic [CvW-1:0] r;
      if (mv < 0) begin
         r = '0;
      end else if (mv > DacMaxMv) begin
         r = CvW'(DacMaxMv);
      end else begin
         r = mv[CvW-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/nctv_if.sv =====
// ----------------------------------------------------------------------------
// Note-to-CV channel interfaces
// Item, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nctv_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [6:0]        pitch;
   logic signed [13:0] bend;
   logic [6:0]        velocity;
   logic              skip_detune;
   modport source (output valid, func, pitch, bend, velocity, skip_detune, input ready);
   modport sink   (input valid, func, pitch, bend, velocity, skip_detune, output ready);
endinterface

interface nctv_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] cv_mv;
   logic [12:0] level;
   logic        gate;
   logic        gliding;
   modport source (output valid, cv_mv, level, gate, gliding, input ready);
   modport sink   (input valid, cv_mv, level, gate, gliding, output ready);
endinterface

interface nctv_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/nctv_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; remainder and dividend bits are preloaded.
// ----------------------------------------------------------------------------
module nctv_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                rem_init,
   input  logic [nctv_pkg::QuotW-1:0] q_init,
   input  logic [31:0]                divisor,
   input  logic [4:0]                 steps,
   output logic                       busy,
   output logic [nctv_pkg::QuotW-1:0] quot
);
   import nctv_pkg::*;

   logic [31:0]      rem_ff, rem_in;
   logic [QuotW-1:0] q_ff, q_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [32:0]      trial;
   logic [32:0]      diff;
   logic             ge;

   assign trial = {rem_ff, q_ff[QuotW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = rem_init;
         q_in   = q_init;
         dvs_in = divisor;
         cnt_in = steps;
      end else if (cnt_ff != 5'd0) begin
         rem_in = ge ? diff[31:0] : trial[31:0];
         q_in   = {q_ff[QuotW-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign busy = cnt_ff != 5'd0;
   assign quot = q_ff;

endmodule

// ===== sv/nctv_ctrl.sv =====
// ----------------------------------------------------------------------------
// Note-to-CV controller
// Sequences note, glide and tick work on the datapath, one item at a time.
// ----------------------------------------------------------------------------
module nctv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nctv_pkg::sts_type sts,
   output nctv_pkg::cmd_type cmd
);
   import nctv_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_NOTE;
            end
         end
         S_NOTE: begin
            case (sts.func)
               FUNC_STOP: begin
                  cmd.stop = 1'b1;
                  state_in = S_DONE;
               end
               FUNC_TICK: begin
                  if (sts.ramp_on) begin
                     cmd.tick = 1'b1;
                     state_in = S_EVAL;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  cmd.note_rel = 1'b1;
                  state_in     = S_MUL;
               end
            endcase
         end
         S_MUL: begin
            cmd.note_mul = 1'b1;
            state_in     = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.note_clamp = 1'b1;
            state_in       = S_ROUTE;
         end
         S_ROUTE: begin
            if (sts.func == FUNC_SET || sts.no_glide) begin
               cmd.set_cv = 1'b1;
               state_in   = S_DONE;
            end else if (sts.prop) begin
               cmd.gap_start = 1'b1;
               state_in      = S_GAPW;
            end else begin
               cmd.ramp_fixed = 1'b1;
               state_in       = S_EVAL;
            end
         end
         S_GAPW: begin
            if (!sts.div_busy) begin
               state_in = S_PLEN;
            end
         end
         S_PLEN: begin
            cmd.ramp_prop = 1'b1;
            state_in      = S_EVAL;
         end
         S_EVAL: begin
            if (sts.ramp_end) begin
               cmd.eval_end = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.ramp_mul = 1'b1;
               state_in     = S_RDIV;
            end
         end
         S_RDIV: begin
            cmd.ramp_div = 1'b1;
            state_in     = S_RWAIT;
         end
         S_RWAIT: begin
            if (!sts.div_busy) begin
               if (sts.chrom) begin
                  cmd.quant_start = 1'b1;
                  state_in        = S_QWAIT;
               end else begin
                  cmd.cv_from_div = 1'b1;
                  state_in        = S_DONE;
               end
            end
         end
         S_QWAIT: begin
            if (!sts.div_busy) begin
               state_in = S_QMUL;
            end
         end
         S_QMUL: begin
            cmd.quant_mul = 1'b1;
            state_in      = S_QCLAMP;
         end
         S_QCLAMP: begin
            cmd.quant_clamp = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.result = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

// ===== sv/nctv_dp.sv =====
// ----------------------------------------------------------------------------
// Note-to-CV datapath
// Registers, pitch multiplier, ramp products, divider and result register.
// ----------------------------------------------------------------------------
module nctv_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  nctv_pkg::cmd_type            cmd,
   output nctv_pkg::sts_type            sts,
   input  logic [1:0]                   req_func,
   input  logic [6:0]                   req_pitch,
   input  logic signed [13:0]           req_bend,
   input  logic [6:0]                   req_velocity,
   input  logic                         req_skip_detune,
   input  logic                         csr_we,
   input  logic [nctv_pkg::CsrIdxW-1:0] csr_index,
   input  logic [nctv_pkg::CsrDatW-1:0] csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nctv_pkg::CvW-1:0]     rsp_cv_mv,
   output logic [nctv_pkg::CvW-1:0]     rsp_level,
   output logic                         rsp_gate,
   output logic                         rsp_gliding
);
   import nctv_pkg::*;

   // configuration
   logic              lane2_ff;
   logic [4:0]        mode_ff;
   logic [5:0]        detune_ff;
   logic [4:0]        brange_ff;
   logic [13:0]       offset_ff;
   logic [15:0]       mvq8_ff;
   logic [15:0]       glide_ff;

   // latched item
   logic [1:0]        func_ff;
   logic [6:0]        pitch_ff;
   logic signed [13:0] bend_ff;
   logic [6:0]        vel_ff;
   logic              skip_ff;

   // lane state
   logic [CvW-1:0]    cur_cv_ff, cur_level_ff, from_ff, to_ff;
   logic              gate_ff, ramp_on_ff;
   logic [31:0]       el_ff, len_ff;

   // work registers
   logic [17:0]        rel_ff;
   logic signed [38:0] prod_ff;
   logic [CvW-1:0]     target_ff;
   logic [44:0]        pa_ff, pb_ff;

   // result register
   logic              rsp_valid_ff;
   logic [CvW-1:0]    rsp_cv_ff, rsp_level_ff;
   logic              rsp_gate_ff, rsp_glide_ff;

   logic               lane0;
   logic signed [13:0] bend_eff;
   logic [9:0]         note_s, note_rel;
   logic signed [19:0] bprod;
   logic signed [19:0] bsh;
   logic [17:0]        rel_calc;
   logic signed [21:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [38:0] mul_p;
   logic signed [38:0] prod_sh;
   logic signed [31:0] mv_sum;
   logic [CvW-1:0]     mv_clamped;
   logic [11:0]        lvl_y;
   logic [24:0]        lvl_p;
   logic [CvW-1:0]     level;
   logic [CvW-1:0]     gap_mv;
   logic [QuotW-1:0]   semis;
   logic [36:0]        len_p;
   logic [31:0]        len_prop;
   logic [44:0]        ramp_sum;

   logic              div_start, div_busy;
   logic [31:0]       div_rem, div_dvs;
   logic [QuotW-1:0]  div_q_init, div_q;
   logic [4:0]        div_steps;

   assign lane0 = !lane2_ff;

   // pitch relative to the lowest note, Q8 semitones
   always_comb begin
      bend_eff = (lane0 && mode_ff[MODE_BEND_OFF]) ? 14'sd0 : bend_ff;
      note_s   = {3'b000, pitch_ff};
      if (lane0 && !skip_ff) begin
         note_s = note_s + {{4{detune_ff[5]}}, detune_ff};
      end
      note_rel = note_s - 10'(MinPitch);
      bprod    = bend_eff * $signed({1'b0, brange_ff});
      bsh      = bprod >>> 5;
      rel_calc = {note_rel, 8'b0} + bsh[17:0];
   end

   assign mul_a = cmd.quant_mul ? $signed({1'b0, semis}) : $signed({{4{rel_ff[17]}}, rel_ff});
   assign mul_b = $signed({1'b0, mvq8_ff});
   assign mul_p = mul_a * mul_b;

   // note products carry Q16, quantized products Q8
   assign prod_sh    = cmd.note_clamp ? (prod_ff >>> 16) : (prod_ff >>> 8);
   assign mv_sum     = prod_sh[31:0] + {{18{offset_ff[13]}}, offset_ff};
   assign mv_clamped = clamp_mv(mv_sum);

   assign lvl_y = {vel_ff, 5'b0};
   assign lvl_p = 25'(lvl_y) * 25'(LevelRecip);
   assign level = {1'b0, vel_ff, 5'b0} + 13'(lvl_p[24:19]);

   assign gap_mv = (cur_cv_ff > target_ff) ? cur_cv_ff - target_ff : target_ff - cur_cv_ff;
   assign semis  = (mvq8_ff == 16'd0) ? '0 : div_q;
   assign len_p  = 37'(glide_ff) * 37'(semis);
   assign len_prop = (len_p[36:32] != 5'd0) ? 32'hFFFF_FFFF : len_p[31:0];
   assign ramp_sum = pa_ff + pb_ff;

   // divider operand select
   always_comb begin
      div_start  = cmd.gap_start || cmd.ramp_div || cmd.quant_start;
      div_rem    = '0;
      div_q_init = {gap_mv, 8'b0};
      div_dvs    = {16'b0, mvq8_ff};
      div_steps  = DivStepsWide;
      if (cmd.ramp_div) begin
         div_rem    = ramp_sum[44:13];
         div_q_init = {ramp_sum[12:0], 8'b0};
         div_dvs    = len_ff;
         div_steps  = DivStepsRamp;
      end else if (cmd.quant_start) begin
         div_q_init = {div_q[CvW-1:0], 8'b0};
      end
   end

   nctv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .q_init   (div_q_init),
      .divisor  (div_dvs),
      .steps    (div_steps),
      .busy     (div_busy),
      .quot     (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lane2_ff     <= 1'b0;
         mode_ff      <= '0;
         detune_ff    <= '0;
         brange_ff    <= 5'd2;
         offset_ff    <= '0;
         mvq8_ff      <= 16'd21333;
         glide_ff     <= '0;
         cur_cv_ff    <= '0;
         cur_level_ff <= '0;
         gate_ff      <= 1'b0;
         ramp_on_ff   <= 1'b0;
         from_ff      <= '0;
         to_ff        <= '0;
         el_ff        <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LANE_SECOND: lane2_ff  <= csr_data[0];
               REG_MODE_BITS:   mode_ff   <= csr_data[4:0];
               REG_DETUNE:      detune_ff <= csr_data[5:0];
               REG_BEND_RANGE:  brange_ff <= csr_data[4:0];
               REG_OFFSET:      offset_ff <= csr_data[13:0];
               REG_MV_PER_SEMI: mvq8_ff   <= csr_data;
               REG_GLIDE_MS:    glide_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.note_clamp) begin
            cur_level_ff <= level;
         end
         if (cmd.set_cv) begin
            cur_cv_ff <= target_ff;
            if (func_ff == FUNC_START) begin
               gate_ff <= 1'b1;
            end
         end
         if (cmd.ramp_fixed || cmd.ramp_prop) begin
            ramp_on_ff <= 1'b1;
            from_ff    <= cur_cv_ff;
            to_ff      <= target_ff;
            el_ff      <= '0;
            len_ff     <= cmd.ramp_prop ? len_prop : 32'(glide_ff);
            gate_ff    <= 1'b1;
         end
         if (cmd.stop) begin
            gate_ff <= 1'b0;
         end
         if (cmd.tick && el_ff != 32'hFFFF_FFFF) begin
            el_ff <= el_ff + 32'd1;
         end
         if (cmd.eval_end) begin
            cur_cv_ff  <= to_ff;
            ramp_on_ff <= 1'b0;
         end
         if (cmd.cv_from_div) begin
            cur_cv_ff <= div_q[CvW-1:0];
         end
         if (cmd.quant_clamp) begin
            cur_cv_ff <= mv_clamped;
         end
         // hold the result until taken
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         pitch_ff <= req_pitch;
         bend_ff  <= req_bend;
         vel_ff   <= req_velocity;
         skip_ff  <= req_skip_detune;
      end
      if (cmd.note_rel) begin
         rel_ff <= rel_calc;
      end
      if (cmd.note_mul || cmd.quant_mul) begin
         prod_ff <= mul_p;
      end
      if (cmd.note_clamp) begin
         target_ff <= mv_clamped;
      end
      if (cmd.ramp_mul) begin
         pa_ff <= 45'(from_ff) * 45'(len_ff - el_ff);
         pb_ff <= 45'(to_ff) * 45'(el_ff);
      end
      if (cmd.result) begin
         rsp_cv_ff    <= cur_cv_ff;
         rsp_level_ff <= cur_level_ff;
         rsp_gate_ff  <= gate_ff;
         rsp_glide_ff <= ramp_on_ff;
      end
   end

   always_comb begin
      sts.func     = func_ff;
      sts.ramp_on  = ramp_on_ff;
      sts.ramp_end = el_ff >= len_ff;
      sts.no_glide = (lane0 && mode_ff[MODE_GLIDE_OFF]) || glide_ff == 16'd0 ||
                     (!gate_ff && mode_ff[MODE_LEGATO]);
      sts.prop     = mode_ff[MODE_PROP];
      sts.chrom    = mode_ff[MODE_CHROMATIC];
      sts.div_busy = div_busy;
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_cv_mv   = rsp_cv_ff;
   assign rsp_level   = rsp_level_ff;
   assign rsp_gate    = rsp_gate_ff;
   assign rsp_gliding = rsp_glide_ff;

endmodule

// ===== sv/note_to_cv_glide_lane.sv =====
// ----------------------------------------------------------------------------
// Note-to-CV glide lane
// Note, stop and millisecond tick items in; pitch CV, level, gate out.
// ----------------------------------------------------------------------------
// Each item yields one result. A stop, or a tick without a running glide,
// goes straight to the result; a note without glide first computes and
// clamps its pitch. A tick that ends the glide sets the CV to its target.
// Any other glide step waits on a ramp division, and chromatic mode adds a
// quantizing division. A proportional note first sizes the gap with a
// division. All divisions share one restoring divider that produces one
// quotient bit per cycle. One item is in work at a time; the next is taken
// once its result sits in the output register. Register writes are accepted
// at any time and must only be made while the lane idles.
module note_to_cv_glide_lane (
   input  logic       clock,
   input  logic       reset,
   nctv_req_if.sink   req_ch,
   nctv_rsp_if.source rsp_ch,
   nctv_csr_if.sink   csr_ch
);
   import nctv_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ch.ready = 1'b1;

   nctv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nctv_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_ch.func),
      .req_pitch       (req_ch.pitch),
      .req_bend        (req_ch.bend),
      .req_velocity    (req_ch.velocity),
      .req_skip_detune (req_ch.skip_detune),
      .csr_we          (csr_ch.valid && csr_ch.ready),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_cv_mv       (rsp_ch.cv_mv),
      .rsp_level       (rsp_ch.level),
      .rsp_gate        (rsp_ch.gate),
      .rsp_gliding     (rsp_ch.gliding)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("lane took a second item right after accept");

   a_result_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.result |=> rsp_ch.valid)
      else $error("finished item did not reach the result register");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.gap_start || cmd.ramp_div || cmd.quant_start) |-> !sts.div_busy)
      else $error("divider restarted while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pending result overwritten");

endmodule
